[hdl/sfw_pkg.sv]
// sfw_pkg: shared types and fixed constants of the span fill word writer
// no dependencies; used by sfw_clip, sfw_mask_unit and span_fill_word_mask_writer_unit
`timescale 1ns / 1ps
`default_nettype none

package sfw_pkg;

  localparam int WORD_W     = 32;
  localparam int ADDR_W     = 13;
  localparam int FIELD_W    = 16;
  localparam int SHIFT_W    = 5;
  localparam int MAX_WRITES = 40;
  localparam int COUNT_W    = $clog2(MAX_WRITES);

  localparam logic MODE_8BPP = 1'b0;
  localparam logic MODE_4BPP = 1'b1;

  // per-word control for the mask shifter
  typedef struct packed {
    logic                 head;
    logic                 tail;
    logic [SHIFT_W-1:0]   head_sh;
    logic [SHIFT_W-1:0]   tail_sh;
  } mask_ctl_t;

endpackage

`default_nettype wire

[hdl/sfw_clip.sv]
// sfw_clip: clips a span to the screen and flags spans that draw nothing
// depends on sfw_pkg for the field width
`timescale 1ns / 1ps
`default_nettype none

module sfw_clip #(
  parameter int SCREEN_WIDTH  = 160,
  parameter int SCREEN_HEIGHT = 160,
  parameter int COL_W         = 8
) (
  input  wire logic signed [sfw_pkg::FIELD_W-1:0] row,
  input  wire logic signed [sfw_pkg::FIELD_W-1:0] span_start,
  input  wire logic signed [sfw_pkg::FIELD_W-1:0] span_end,
  output logic                                    span_ok,
  output logic [COL_W-1:0]                        start_col,
  output logic [COL_W-1:0]                        end_col
);
  import sfw_pkg::*;

  localparam logic signed [FIELD_W-1:0] WIDTH_S  = FIELD_W'(SCREEN_WIDTH);
  localparam logic signed [FIELD_W-1:0] HEIGHT_S = FIELD_W'(SCREEN_HEIGHT);
  localparam logic [COL_W-1:0]          LAST_COL = COL_W'(SCREEN_WIDTH - 1);

  logic row_ok;
  logic on_screen;

  always_comb begin
    row_ok    = (row >= 0) && (row < HEIGHT_S);
    on_screen = (span_start < WIDTH_S) && (span_end >= 0);
    start_col = (span_start < 0) ? '0 : span_start[COL_W-1:0];
    end_col   = (span_end > WIDTH_S - 1) ? LAST_COL : span_end[COL_W-1:0];
    // reversed span after clipping draws nothing
    span_ok   = row_ok && on_screen && (start_col <= end_col);
  end

endmodule

`default_nettype wire

[hdl/sfw_mask_unit.sv]
// sfw_mask_unit: shared shifter building the lane mask of the current word
// depends on sfw_pkg for mask_ctl_t
`timescale 1ns / 1ps
`default_nettype none

module sfw_mask_unit (
  input  wire sfw_pkg::mask_ctl_t         ctl,
  output logic [sfw_pkg::WORD_W-1:0]      lane_mask
);
  import sfw_pkg::*;

  logic [WORD_W-1:0] head_mask;
  logic [WORD_W-1:0] tail_mask;

  always_comb begin
    head_mask = {WORD_W{1'b1}} >> ctl.head_sh;
    tail_mask = {WORD_W{1'b1}} << ctl.tail_sh;
    lane_mask = {WORD_W{1'b1}};
    if (ctl.head) begin
      lane_mask = lane_mask & head_mask;
    end
    if (ctl.tail) begin
      lane_mask = lane_mask & tail_mask;
    end
  end

endmodule

`default_nettype wire

[hdl/span_fill_word_mask_writer_unit.sv]
// span_fill_word_mask_writer_unit: span to masked framebuffer word writes
// depends on sfw_pkg, sfw_clip and sfw_mask_unit
//
// channel | signals                                   | direction
// in      | in_valid, in_ready, row, span_start,      | input transaction
//         | span_end, fill_value                      |
// out     | out_valid, out_ready, word_address,       | output transaction
//         | lane_mask, write_data, last_write         |
// cfg     | cfg_valid, cfg_ready, cfg_pixel_mode      | register write
//
// a span is taken in idle, then clipped with its base address formed in the check state
// (one small multiply), then written at one word per cycle, while out does not stall,
// through the shared mask shifter; a span that draws nothing returns to idle with no writes
// a stall on out holds the current word; no new span is taken until the last
// word is handed over. synchronous active-high reset clears control and mode
`timescale 1ns / 1ps
`default_nettype none

module span_fill_word_mask_writer_unit #(
  parameter int SCREEN_WIDTH  = 160,
  parameter int SCREEN_HEIGHT = 160
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [sfw_pkg::FIELD_W-1:0]     row,
  input  wire logic signed [sfw_pkg::FIELD_W-1:0]     span_start,
  input  wire logic signed [sfw_pkg::FIELD_W-1:0]     span_end,
  input  wire logic [sfw_pkg::WORD_W-1:0]             fill_value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [sfw_pkg::ADDR_W-1:0]                  word_address,
  output logic [sfw_pkg::WORD_W-1:0]                  lane_mask,
  output logic [sfw_pkg::WORD_W-1:0]                  write_data,
  output logic                                        last_write,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic                                   cfg_pixel_mode
);
  import sfw_pkg::*;

  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int WPR8   = (SCREEN_WIDTH + 3) / 4;
  localparam int WPR4   = (SCREEN_WIDTH + 7) / 8;
  localparam int WPR_W  = $clog2(WPR8 + 1);
  localparam int PROD_W = ROW_W + WPR_W;
  localparam int SUM_W  = ((PROD_W > COL_W) ? PROD_W : COL_W) + 1;
  localparam int AW     = (SUM_W > ADDR_W) ? SUM_W : ADDR_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]                state;
  logic                      pixel_mode;
  logic signed [FIELD_W-1:0] span_row;
  logic signed [FIELD_W-1:0] span_lo;
  logic signed [FIELD_W-1:0] span_hi;
  logic [WORD_W-1:0]         fill;
  logic [COL_W-1:0]          cur_word;
  logic [COL_W-1:0]          last_word;
  logic [ADDR_W-1:0]         addr;
  logic [COUNT_W-1:0]        word_count;
  logic                      at_first;
  logic [SHIFT_W-1:0]        head_sh;
  logic [SHIFT_W-1:0]        tail_sh;

  logic                      span_ok;
  logic [COL_W-1:0]          start_col;
  logic [COL_W-1:0]          end_col;
  logic [COL_W-1:0]          first_word_next;
  logic [COL_W-1:0]          last_word_next;
  logic [SHIFT_W-1:0]        head_sh_next;
  logic [SHIFT_W-1:0]        tail_sh_next;
  logic [WPR_W-1:0]          wpr;
  logic [PROD_W-1:0]         row_base;
  logic [AW-1:0]             addr_sum;
  logic                      is_last;
  mask_ctl_t                 mask_ctl;

  sfw_clip #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .COL_W         (COL_W)
  ) u_clip (
    .row        (span_row),
    .span_start (span_lo),
    .span_end   (span_hi),
    .span_ok    (span_ok),
    .start_col  (start_col),
    .end_col    (end_col)
  );

  always_comb begin
    if (pixel_mode == MODE_4BPP) begin
      wpr             = WPR_W'(WPR4);
      first_word_next = start_col >> 3;
      last_word_next  = end_col >> 3;
      head_sh_next    = {start_col[2:0], 2'b00};
      tail_sh_next    = {~end_col[2:0], 2'b00};
    end else begin
      wpr             = WPR_W'(WPR8);
      first_word_next = start_col >> 2;
      last_word_next  = end_col >> 2;
      head_sh_next    = {start_col[1:0], 3'b000};
      tail_sh_next    = {~end_col[1:0], 3'b000};
    end
    row_base = PROD_W'(span_row[ROW_W-1:0]) * PROD_W'(wpr);
    addr_sum = AW'(row_base) + AW'(first_word_next);
  end

  // word cut short once the write limit is reached
  assign is_last = (cur_word == last_word) || (word_count == COUNT_W'(MAX_WRITES - 1));

  // fields in order: head, tail, head_sh, tail_sh
  assign mask_ctl = {at_first, (cur_word == last_word), head_sh, tail_sh};

  sfw_mask_unit u_mask (
    .ctl       (mask_ctl),
    .lane_mask (lane_mask)
  );

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_EMIT);
  assign cfg_ready    = 1'b1;
  assign word_address = addr;
  assign write_data   = fill;
  assign last_write   = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pixel_mode <= MODE_8BPP;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pixel_mode <= cfg_pixel_mode;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= span_ok ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_ready && is_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      span_row <= row;
      span_lo  <= span_start;
      span_hi  <= span_end;
      fill     <= fill_value;
    end
    if (state == S_CHECK) begin
      cur_word   <= first_word_next;
      last_word  <= last_word_next;
      addr       <= addr_sum[ADDR_W-1:0];
      head_sh    <= head_sh_next;
      tail_sh    <= tail_sh_next;
      word_count <= '0;
      at_first   <= 1'b1;
    end else if (state == S_EMIT && out_ready) begin
      cur_word   <= cur_word + COL_W'(1);
      addr       <= addr + ADDR_W'(1);
      word_count <= word_count + COUNT_W'(1);
      at_first   <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("span taken while words still pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_write) |=> in_ready)
    else $error("no return to idle after final word");

  a_write_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_count < COUNT_W'(MAX_WRITES)))
    else $error("word write limit exceeded");

  a_first_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !at_first)
    else $error("head mask applied past first word");
`endif

endmodule

`default_nettype wire
